/* sv/wlpm_pkg.sv */
// types, codes and helpers shared by the wakelock power mode controller
package wlpm_pkg;

	localparam int LOCK_SLOTS = 8;
	localparam int SLOT_IDX_W = (LOCK_SLOTS > 1) ? $clog2(LOCK_SLOTS) : 1;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] CFG_IDLE_TIMEOUT     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IDLE_TARGET_MODE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SLEEP_DURATION   = 2'd2;

	localparam logic [1:0] OP_ACQUIRE = 2'd0;
	localparam logic [1:0] OP_RELEASE = 2'd1;
	localparam logic [1:0] OP_SET     = 2'd2;
	localparam logic [1:0] OP_TICK    = 2'd3;

	localparam logic [1:0] MODE_ACTIVE = 2'd0;
	localparam logic [1:0] MODE_LIGHT  = 2'd2;
	localparam logic [1:0] MODE_DEEP   = 2'd3;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_BAD_SLOT  = 3'd1;
	localparam logic [2:0] ST_BAD_STATE = 3'd2;
	localparam logic [2:0] ST_NO_SLOT   = 3'd3;
	localparam logic [2:0] ST_HALTED    = 3'd4;

	typedef logic [1:0] mode_t;

	typedef struct packed {
		logic [23:0] idle_timeout;
		mode_t       idle_target_mode;
		logic [31:0] sleep_duration;
	} cfg_t;

	typedef struct packed {
		logic [1:0] opcode;
		logic [3:0] lock_slot;
		mode_t      requested_mode;
	} item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [2:0]  granted_slot;
		logic        mode_changed;
		mode_t       mode_before;
		mode_t       mode_after;
		logic        sleep_request;
		logic [31:0] sleep_time;
		logic [3:0]  locks_held;
	} res_t;

	// lowest free slot, found flag on top
	function automatic logic [SLOT_IDX_W:0] find_free(input logic [LOCK_SLOTS-1:0] busy);
		logic [SLOT_IDX_W:0] r;
		r = '0;
		for (int i = LOCK_SLOTS - 1; i >= 0; i--) begin
			if (!busy[i]) begin
				r = {1'b1, SLOT_IDX_W'(i)};
			end
		end
		return r;
	endfunction

endpackage

/* sv/wlpm_if.sv */
// valid/ready channels for commands and results
interface wlpm_cmd_if;
	logic       valid;
	logic       ready;
	logic [1:0] opcode;
	logic [3:0] lock_slot;
	logic [1:0] requested_mode;

	modport source (output valid, output opcode, output lock_slot, output requested_mode,
		input ready);
	modport sink (input valid, input opcode, input lock_slot, input requested_mode,
		output ready);
endinterface

interface wlpm_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [2:0]  granted_slot;
	logic        mode_changed;
	logic [1:0]  mode_before;
	logic [1:0]  mode_after;
	logic        sleep_request;
	logic [31:0] sleep_time;
	logic [3:0]  locks_held;

	modport source (output valid, output status, output granted_slot, output mode_changed,
		output mode_before, output mode_after, output sleep_request, output sleep_time,
		output locks_held, input ready);
	modport sink (input valid, input status, input granted_slot, input mode_changed,
		input mode_before, input mode_after, input sleep_request, input sleep_time,
		input locks_held, output ready);
endinterface

/* sv/wlpm_cfg_regs.sv */
// configuration registers behind the plain write port
module wlpm_cfg_regs
	import wlpm_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wen,
	input  logic [CFG_IDX_W-1:0]  index,
	input  logic [CFG_DATA_W-1:0] data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.idle_timeout     <= '0;
			cfg_q.idle_target_mode <= MODE_LIGHT;
			cfg_q.sleep_duration   <= '0;
		end else if (wen) begin
			case (index)
				CFG_IDLE_TIMEOUT:     cfg_q.idle_timeout     <= data[23:0];
				CFG_IDLE_TARGET_MODE: cfg_q.idle_target_mode <= data[1:0];
				CFG_SLEEP_DURATION:   cfg_q.sleep_duration   <= data[31:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* sv/wlpm_core.sv */
// lock slots, power mode, idle timer and the per-item update
module wlpm_core
	import wlpm_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  cfg_t  cfg,
	input  logic  step,
	input  item_t item,
	output res_t  res
);

	logic [LOCK_SLOTS-1:0] busy_q, busy_d;
	logic [3:0]            total_q, total_d, total_dec;
	mode_t                 mode_q, mode_d;
	logic                  armed_q, armed_d;
	logic [23:0]           elapsed_q, elapsed_d, elapsed_inc;
	logic                  halted_q, halted_d;
	logic [SLOT_IDX_W:0]   free;
	logic [SLOT_IDX_W-1:0] rel_idx;

	assign free        = find_free(busy_q);
	assign rel_idx     = item.lock_slot[SLOT_IDX_W-1:0];
	assign total_dec   = (total_q != 4'd0) ? total_q - 4'd1 : total_q;
	assign elapsed_inc = (elapsed_q == '1) ? elapsed_q : elapsed_q + 24'd1;

	always_comb begin
		busy_d    = busy_q;
		total_d   = total_q;
		mode_d    = mode_q;
		armed_d   = armed_q;
		elapsed_d = elapsed_q;
		halted_d  = halted_q;

		res.status        = ST_OK;
		res.granted_slot  = '0;
		res.mode_changed  = 1'b0;
		res.mode_before   = mode_q;
		res.sleep_request = 1'b0;
		res.sleep_time    = '0;

		if (halted_q) begin
			res.status = ST_HALTED;
		end else begin
			case (item.opcode)
				OP_ACQUIRE: begin
					if (!free[SLOT_IDX_W]) begin
						res.status = ST_NO_SLOT;
					end else begin
						busy_d[free[SLOT_IDX_W-1:0]] = 1'b1;
						total_d          = total_q + 4'd1;
						res.granted_slot = 3'(free[SLOT_IDX_W-1:0]);
						armed_d          = 1'b0;
						elapsed_d        = '0;
						if (mode_q != MODE_ACTIVE) begin
							res.mode_changed = 1'b1;
							mode_d           = MODE_ACTIVE;
						end
					end
				end
				OP_RELEASE: begin
					if (item.lock_slot >= 4'(LOCK_SLOTS)) begin
						res.status = ST_BAD_SLOT;
					end else if (!busy_q[rel_idx]) begin
						res.status = ST_BAD_STATE;
					end else begin
						busy_d[rel_idx] = 1'b0;
						total_d         = total_dec;
						if (total_dec == 4'd0 && cfg.idle_timeout != '0) begin
							armed_d   = 1'b1;
							elapsed_d = '0;
						end
					end
				end
				OP_SET: begin
					if (item.requested_mode == MODE_DEEP) begin
						if (total_q != 4'd0) begin
							res.status = ST_BAD_STATE;
						end else begin
							res.sleep_request = 1'b1;
							res.sleep_time    = cfg.sleep_duration;
							halted_d          = 1'b1;
						end
					end else if (item.requested_mode != mode_q) begin
						res.mode_changed = 1'b1;
						mode_d           = item.requested_mode;
					end
				end
				OP_TICK: begin
					if (armed_q) begin
						elapsed_d = elapsed_inc;
						if (elapsed_inc >= cfg.idle_timeout) begin
							armed_d   = 1'b0;
							elapsed_d = '0;
							if (total_q == 4'd0) begin
								if (cfg.idle_target_mode == MODE_DEEP) begin
									res.sleep_request = 1'b1;
									res.sleep_time    = cfg.sleep_duration;
									halted_d          = 1'b1;
								end else if (cfg.idle_target_mode != mode_q) begin
									res.mode_changed = 1'b1;
									mode_d           = cfg.idle_target_mode;
								end
							end
						end
					end
				end
				default: begin
				end
			endcase
		end

		res.mode_after = mode_d;
		res.locks_held = total_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= '0;
			total_q   <= '0;
			mode_q    <= MODE_ACTIVE;
			armed_q   <= 1'b0;
			elapsed_q <= '0;
			halted_q  <= 1'b0;
		end else if (step) begin
			busy_q    <= busy_d;
			total_q   <= total_d;
			mode_q    <= mode_d;
			armed_q   <= armed_d;
			elapsed_q <= elapsed_d;
			halted_q  <= halted_d;
		end
	end

`ifndef NO_ASSERTIONS
	a_count_matches_slots: assert property (@(posedge clk) disable iff (!arst_n)
		32'(total_q) == $countones(busy_q))
		else $error("lock count differs from busy slots");

	a_armed_only_unlocked: assert property (@(posedge clk) disable iff (!arst_n)
		armed_q |-> total_q == 4'd0)
		else $error("idle timer armed while locks held");

	a_halt_is_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |=> halted_q && $stable(busy_q) && $stable(mode_q))
		else $error("state moved while halted");

	a_sleep_only_unlocked: assert property (@(posedge clk) disable iff (!arst_n)
		step && res.sleep_request |-> total_q == 4'd0 && !halted_q)
		else $error("deep sleep requested with locks held");
`endif

endmodule

/* sv/wakelock_power_mode_controller.sv */
// Wakelock power mode controller, top level.
//
// cmd carries one opcode per transfer: acquire, release, set mode or an
// idle timer tick. rsp returns exactly one result per command, in order.
// Registers idle_timeout, idle_target_mode and sleep_duration are written
// through cfg_wen / cfg_index / cfg_data while no command is in flight.
//
// A command transfer lands in an input register; when the output register is
// empty or being taken, the state update and the result are computed and the
// result lands in the output register, from which it is offered on rsp.
// One command per cycle is sustained while rsp takes each result: the input
// register refills in the same cycle that it drains into the output register.
// When rsp is stalled the output register holds, the input register holds
// one more command, and then cmd.ready drops until rsp takes a transfer.
// Reset clears all slots, sets active mode, disarms the idle timer, clears
// the halt, and loads the register reset values (idle target is light sleep).
// After a granted deep sleep request every command answers status halted.
module wakelock_power_mode_controller
	import wlpm_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	wlpm_cmd_if.sink              cmd,
	wlpm_rsp_if.source            rsp,
	input  logic                  cfg_wen,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t  cfg;
	item_t item_s1;
	logic  valid_s1;
	res_t  res;
	res_t  res_q;
	logic  valid_q;
	logic  step;

	assign step      = valid_s1 && (!valid_q || rsp.ready);
	assign cmd.ready = !valid_s1 || step;

	wlpm_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.wen    (cfg_wen),
		.index  (cfg_index),
		.data   (cfg_data),
		.cfg    (cfg)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ready && cmd.valid) begin
			item_s1.opcode         <= cmd.opcode;
			item_s1.lock_slot      <= cmd.lock_slot;
			item_s1.requested_mode <= cmd.requested_mode;
		end
	end

	wlpm_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.step   (step),
		.item   (item_s1),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (step) begin
			valid_q <= 1'b1;
		end else if (rsp.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_q <= res;
		end
	end

	assign rsp.valid         = valid_q;
	assign rsp.status        = res_q.status;
	assign rsp.granted_slot  = res_q.granted_slot;
	assign rsp.mode_changed  = res_q.mode_changed;
	assign rsp.mode_before   = res_q.mode_before;
	assign rsp.mode_after    = res_q.mode_after;
	assign rsp.sleep_request = res_q.sleep_request;
	assign rsp.sleep_time    = res_q.sleep_time;
	assign rsp.locks_held    = res_q.locks_held;

endmodule

/* test/wlpm_checker.sv */
`timescale 1ns / 1ps
// checker: predicts each controller result from commands and register writes, then compares
module wlpm_checker
	import wlpm_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	wlpm_cmd_if                   cmd,
	wlpm_rsp_if                   rsp,
	input  logic                  cfg_wen,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    errors,
	output int                    pending
);

	localparam logic [23:0] ELAPSED_MAX = 24'hFF_FFFF;

	logic [23:0]           idle_timeout;
	mode_t                 idle_target;
	logic [31:0]           sleep_dur;
	logic [LOCK_SLOTS-1:0] slot_busy;
	logic [3:0]            lock_total;
	mode_t                 power_mode;
	logic                  timer_armed;
	logic [23:0]           idle_elapsed;
	logic                  halted;
	res_t                  results_due[$];
	res_t                  seen;
	res_t                  want;
	item_t                 taken_cmd;

	function automatic void change_mode(input mode_t m, inout res_t r);
		if (m != power_mode) begin
			r.mode_changed = 1'b1;
			r.mode_before = power_mode;
			power_mode = m;
		end
	endfunction

	function automatic void try_deep_sleep(inout res_t r);
		if (lock_total != 0) begin
			r.status = ST_BAD_STATE;
		end else begin
			r.sleep_request = 1'b1;
			r.sleep_time = sleep_dur;
			halted = 1'b1;
		end
	endfunction

	function automatic res_t power_step(input item_t it);
		res_t r;
		logic found;
		r = '0;
		r.status = ST_OK;
		r.mode_before = power_mode;
		found = 1'b0;
		if (halted) begin
			r.status = ST_HALTED;
		end else begin
			case (it.opcode)
				OP_ACQUIRE: begin
					for (int i = 0; i < LOCK_SLOTS; i++) begin
						if (!found && !slot_busy[i]) begin
							found = 1'b1;
							slot_busy[i] = 1'b1;
							lock_total = lock_total + 4'd1;
							r.granted_slot = 3'(i);
							timer_armed = 1'b0;
							idle_elapsed = '0;
							change_mode(MODE_ACTIVE, r);
						end
					end
					if (!found) r.status = ST_NO_SLOT;
				end
				OP_RELEASE: begin
					if (it.lock_slot >= LOCK_SLOTS) begin
						r.status = ST_BAD_SLOT;
					end else if (!slot_busy[it.lock_slot[SLOT_IDX_W-1:0]]) begin
						r.status = ST_BAD_STATE;
					end else begin
						slot_busy[it.lock_slot[SLOT_IDX_W-1:0]] = 1'b0;
						if (lock_total != 0) lock_total = lock_total - 4'd1;
						if (lock_total == 0 && idle_timeout != 0) begin
							timer_armed = 1'b1;
							idle_elapsed = '0;
						end
					end
				end
				OP_SET: begin
					if (it.requested_mode == MODE_DEEP) try_deep_sleep(r);
					else change_mode(it.requested_mode, r);
				end
				OP_TICK: begin
					if (timer_armed) begin
						if (idle_elapsed != ELAPSED_MAX) idle_elapsed = idle_elapsed + 24'd1;
						if (idle_elapsed >= idle_timeout) begin
							timer_armed = 1'b0;
							idle_elapsed = '0;
							if (lock_total == 0) begin
								if (idle_target == MODE_DEEP) try_deep_sleep(r);
								else change_mode(idle_target, r);
							end
						end
					end
				end
				default: ;
			endcase
		end
		r.mode_after = power_mode;
		r.locks_held = lock_total;
		return r;
	endfunction

	function automatic string show(input res_t r);
		return $sformatf({"status=%0d slot=%0d changed=%0b old=%0d new=%0d",
			" sleep=%0b time=%h locks=%0d"},
			r.status, r.granted_slot, r.mode_changed, r.mode_before, r.mode_after,
			r.sleep_request, r.sleep_time, r.locks_held);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_timeout = '0;
			idle_target = MODE_LIGHT;
			sleep_dur = '0;
			slot_busy = '0;
			lock_total = '0;
			power_mode = MODE_ACTIVE;
			timer_armed = 1'b0;
			idle_elapsed = '0;
			halted = 1'b0;
			results_due.delete();
			errors <= 0;
			pending <= 0;
		end else begin
			if (cfg_wen) begin
				case (cfg_index)
					CFG_IDLE_TIMEOUT: idle_timeout = cfg_data[23:0];
					CFG_IDLE_TARGET_MODE: idle_target = mode_t'(cfg_data[1:0]);
					CFG_SLEEP_DURATION: sleep_dur = cfg_data;
					default: ;
				endcase
			end
			if (rsp.valid && rsp.ready) begin
				seen = {rsp.status, rsp.granted_slot, rsp.mode_changed, rsp.mode_before,
					rsp.mode_after, rsp.sleep_request, rsp.sleep_time, rsp.locks_held};
				if (results_due.size() == 0) begin
					if (errors < 10)
						$display("%t unexpected result transfer: %s", $realtime, show(seen));
					errors <= errors + 1;
				end else begin
					want = results_due.pop_front();
					if (seen !== want) begin
						if (errors < 10) begin
							$display("%t result mismatch", $realtime);
							$display("  expected %s", show(want));
							$display("  actual   %s", show(seen));
						end
						errors <= errors + 1;
					end
				end
			end
			if (cmd.valid && cmd.ready) begin
				taken_cmd = {cmd.opcode, cmd.lock_slot, cmd.requested_mode};
				results_due.push_back(power_step(taken_cmd));
			end
			pending <= results_due.size();
		end
	end

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps
// testbench top: clock, reset, command and register stimulus, watchdog and verdict
module tb;
	import wlpm_pkg::*;

	localparam int STALL_LIMIT   = 2000;
	localparam int HOLD_CYCLES   = 150;
	localparam int RANDOM_PHASES = 6;
	localparam int PHASE_ITEMS   = 110;

	typedef enum {FLOW, SOME_STALL, MOSTLY_STALL, EVERY_THIRD} stall_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_wen = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	int                    errors;
	int                    pending;
	logic [LOCK_SLOTS-1:0] held;
	int                    burst_left;
	int                    quiet_cycles = 0;

	wlpm_cmd_if cmd_ch();
	wlpm_rsp_if rsp_ch();

	wakelock_power_mode_controller dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_ch),
		.rsp(rsp_ch),
		.cfg_wen(cfg_wen),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	wlpm_checker mode_check (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_ch),
		.rsp(rsp_ch),
		.cfg_wen(cfg_wen),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.errors(errors),
		.pending(pending)
	);

	always #5 clk = ~clk;

	task automatic write_regs(input logic [23:0] timeout, input mode_t target,
		input logic [31:0] dur);
		cfg_wen <= 1'b1;
		cfg_index <= CFG_IDLE_TIMEOUT;
		cfg_data <= 32'(timeout);
		@(posedge clk);
		cfg_index <= CFG_IDLE_TARGET_MODE;
		cfg_data <= 32'(target);
		@(posedge clk);
		cfg_index <= CFG_SLEEP_DURATION;
		cfg_data <= dur;
		@(posedge clk);
		cfg_wen <= 1'b0;
	endtask

	task automatic push_cmd(input logic [1:0] op, input logic [3:0] slot, input mode_t m);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 7);
			if (gap != 0) begin
				cmd_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 30);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.opcode <= op;
		cmd_ch.lock_slot <= slot;
		cmd_ch.requested_mode <= m;
		@(posedge clk);
		while (!cmd_ch.ready) @(posedge clk);
		burst_left--;
		// track which slots should be busy so deep sleep is never granted early
		if (op == OP_ACQUIRE) held = held | (held + 1'b1);
		else if (op == OP_RELEASE && slot < LOCK_SLOTS) held[slot[SLOT_IDX_W-1:0]] = 1'b0;
	endtask

	task automatic drain;
		cmd_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	function automatic item_t random_command(input int acq_w, input int rel_w);
		item_t it;
		int r;
		int s;
		it.opcode = OP_TICK;
		it.lock_slot = 4'($urandom_range(15));
		it.requested_mode = mode_t'($urandom_range(3));
		r = $urandom_range(99);
		if (r < acq_w) begin
			it.opcode = OP_ACQUIRE;
		end else if (r < acq_w + rel_w) begin
			it.opcode = OP_RELEASE;
			if (held != '0 && $urandom_range(4) != 0) begin
				do s = $urandom_range(LOCK_SLOTS - 1); while (!held[s]);
				it.lock_slot = 4'(s);
			end
		end else if (r < acq_w + rel_w + 12) begin
			it.opcode = OP_SET;
			if (held == '0 && it.requested_mode == MODE_DEEP)
				it.requested_mode = mode_t'($urandom_range(2));
		end
		return it;
	endfunction

	always @(posedge clk) begin
		if (!arst_n || (cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin : rsp_side
		stall_t stall_kind;
		int     kind_left;
		int     taken;
		int     holds_done;
		rsp_ch.ready = 1'b0;
		stall_kind = FLOW;
		kind_left = 0;
		taken = 0;
		holds_done = 0;
		forever begin
			@(posedge clk);
			if (rsp_ch.valid && rsp_ch.ready) taken++;
			// long hold-off while commands keep coming so the input side backs up
			if (holds_done < 2 && taken >= 150 + 270 * holds_done && cmd_ch.valid) begin
				rsp_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				holds_done++;
			end
			if (kind_left == 0) begin
				stall_kind = stall_t'($urandom_range(3));
				kind_left = $urandom_range(20, 120);
			end
			kind_left--;
			case (stall_kind)
				FLOW: rsp_ch.ready <= 1'b1;
				SOME_STALL: rsp_ch.ready <= ($urandom_range(3) != 0);
				MOSTLY_STALL: rsp_ch.ready <= ($urandom_range(4) == 0);
				EVERY_THIRD: rsp_ch.ready <= (kind_left % 3 == 0);
				default: rsp_ch.ready <= 1'b1;
			endcase
		end
	end

	initial begin : stimulus
		item_t       it;
		int          acq_w;
		int          rel_w;
		logic [23:0] timeout;
		logic [31:0] dur;
		cmd_ch.valid = 1'b0;
		cmd_ch.opcode = OP_TICK;
		cmd_ch.lock_slot = '0;
		cmd_ch.requested_mode = MODE_ACTIVE;
		held = '0;
		burst_left = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_regs(24'd3, MODE_ACTIVE, 32'hFFFF_FFFF);
		push_cmd(OP_TICK, 4'd9, MODE_DEEP);
		push_cmd(OP_SET, 4'd0, MODE_LIGHT);
		push_cmd(OP_SET, 4'd15, MODE_LIGHT);
		push_cmd(OP_RELEASE, 4'd15, MODE_ACTIVE);
		push_cmd(OP_RELEASE, 4'd0, MODE_ACTIVE);
		repeat (LOCK_SLOTS) push_cmd(OP_ACQUIRE, 4'd6, MODE_DEEP);
		push_cmd(OP_ACQUIRE, 4'd0, MODE_ACTIVE);
		push_cmd(OP_SET, 4'd0, MODE_DEEP);
		for (int s = LOCK_SLOTS - 1; s >= 0; s--) push_cmd(OP_RELEASE, 4'(s), MODE_ACTIVE);
		// idle expiry into the mode already active
		repeat (3) push_cmd(OP_TICK, 4'd0, MODE_ACTIVE);
		push_cmd(OP_ACQUIRE, 4'd0, MODE_ACTIVE);
		push_cmd(OP_RELEASE, 4'd0, MODE_ACTIVE);
		push_cmd(OP_TICK, 4'd0, MODE_ACTIVE);
		drain();
		// timeout cleared while armed, next tick expires
		write_regs(24'd0, MODE_LIGHT, 32'd0);
		push_cmd(OP_TICK, 4'd0, MODE_ACTIVE);

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			drain();
			case (ph)
				0: timeout = 24'd0;
				1: timeout = 24'hFF_FFFF;
				2: timeout = 24'd1;
				default: timeout = 24'($urandom_range(2, 12));
			endcase
			dur = (ph == 1) ? 32'hFFFF_FFFF : (ph == 2) ? 32'd0 : $urandom;
			write_regs(timeout, mode_t'(ph % 3), dur);
			acq_w = $urandom_range(15, 40);
			rel_w = $urandom_range(15, 40);
			repeat (PHASE_ITEMS) begin
				it = random_command(acq_w, rel_w);
				push_cmd(it.opcode, it.lock_slot, it.requested_mode);
			end
		end

		// enter deep sleep, by command or by idle expiry, then everything is refused
		drain();
		write_regs(24'd2, MODE_DEEP, $urandom);
		push_cmd(OP_ACQUIRE, 4'd0, MODE_ACTIVE);
		for (int s = 0; s < LOCK_SLOTS; s++) begin
			if (held[s]) push_cmd(OP_RELEASE, 4'(s), MODE_ACTIVE);
		end
		if ($urandom_range(1) != 0) push_cmd(OP_SET, 4'd0, MODE_DEEP);
		else repeat (2) push_cmd(OP_TICK, 4'd0, MODE_ACTIVE);
		repeat (12) begin
			it = random_command(25, 25);
			push_cmd(it.opcode, it.lock_slot, it.requested_mode);
		end
		drain();
		repeat (4) @(posedge clk);
		if (errors == 0) $display("*** PASSED ***");
		else $display("*** FAILED ***");
		$finish;
	end

endmodule

/* wakelock_power_mode_controller.f */
sv/wlpm_pkg.sv
sv/wlpm_if.sv
sv/wlpm_cfg_regs.sv
sv/wlpm_core.sv
sv/wakelock_power_mode_controller.sv
test/wlpm_checker.sv
test/tb.sv
